FILE: rtl/kse_pkg.sv
// shared types and constants for the key square move engine
// move cut points, opcodes, move kinds and the transaction structs
// no dependencies
package kse_pkg;

    localparam int SIDE_DEF  = 5;
    localparam int CELLS_DEF = 25;
    localparam int OP_W      = 2;
    localparam int DRAW_W    = 16;
    localparam int CELL_W    = 5;
    localparam int LINE_W    = 3;
    localparam int VAL_W     = 5;
    localparam int KIND_W    = 3;

    // draw thresholds, fraction of 65536 rounded up
    localparam logic [DRAW_W-1:0] CUT_CELL  = 16'd52429;
    localparam logic [DRAW_W-1:0] CUT_ROWS  = 16'd57672;
    localparam logic [DRAW_W-1:0] CUT_COLS  = 16'd62915;
    localparam logic [DRAW_W-1:0] CUT_REV   = 16'd64226;
    localparam logic [DRAW_W-1:0] CUT_FROWS = 16'd64881;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD = 2'd0,
        OP_MOVE = 2'd1,
        OP_READ = 2'd2
    } opcode_t;

    typedef enum logic [KIND_W-1:0] {
        MK_CELL  = 3'd0,
        MK_ROWS  = 3'd1,
        MK_COLS  = 3'd2,
        MK_REV   = 3'd3,
        MK_FROWS = 3'd4,
        MK_FCOLS = 3'd5,
        MK_NONE  = 3'd6
    } kind_t;

    typedef struct packed {
        opcode_t             opcode;
        logic                square_sel;
        logic [DRAW_W-1:0]   move_draw;
        logic [CELL_W-1:0]   cell_a;
        logic [CELL_W-1:0]   cell_b;
        logic [LINE_W-1:0]   line_a;
        logic [LINE_W-1:0]   line_b;
    } item_t;

    typedef struct packed {
        logic  load;
        logic  apply;
        kind_t kind;
    } move_ctrl_t;

endpackage

FILE: rtl/key_square_move_engine.sv
// top level of the key square move engine: input register, move logic, result register
// depends on kse_pkg, kse_move_select and kse_square_bank
//
//  port group   direction  fields, lowest bit first
//  s_*          in         tuser: opcode[1:0] square_sel[2]
//                          tdata: move_draw cell_a cell_b line_a line_b
//  m_*          out        tuser: move_kind[2:0]  tdata: read_value[4:0]
//
//  one transaction per cycle while m_tready is high, registered in and out
//  the square update and the cell read share one combinational pass
//  synchronous active-low reset loads the identity order into both squares
//  a stalled result holds the input register, then s_tready drops
module key_square_move_engine import kse_pkg::*; #(
    parameter int SIDE  = SIDE_DEF,
    parameter int CELLS = CELLS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // move_draw, cell_a, cell_b, line_a, line_b
    input  logic [2:0]  s_tuser,   // opcode, square_sel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // read_value, zero fill
    output logic [2:0]  m_tuser    // move_kind
);

    item_t             in_item_reg;
    item_t             in_item_next;
    logic              in_valid_reg;
    logic              in_valid_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [VAL_W-1:0]  out_value_reg;
    logic [VAL_W-1:0]  out_value_next;
    kind_t             out_kind_reg;
    kind_t             out_kind_next;
    logic              advance;
    move_ctrl_t        ctrl;
    logic [VAL_W-1:0]  read_value;
    item_t             s_item;

    always_comb begin
        s_item.opcode     = opcode_t'(s_tuser[1:0]);
        s_item.square_sel = s_tuser[2];
        s_item.move_draw  = s_tdata[15:0];
        s_item.cell_a     = s_tdata[20:16];
        s_item.cell_b     = s_tdata[25:21];
        s_item.line_a     = s_tdata[28:26];
        s_item.line_b     = s_tdata[31:29];
    end

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    kse_move_select u_select (
        .item (in_item_reg),
        .ctrl (ctrl)
    );

    kse_square_bank #(
        .SIDE  (SIDE),
        .CELLS (CELLS)
    ) u_bank (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .advance    (advance),
        .item       (in_item_reg),
        .ctrl       (ctrl),
        .read_value (read_value)
    );

    always_comb begin
        in_valid_next  = in_valid_reg;
        in_item_next   = in_item_reg;
        out_valid_next = out_valid_reg;
        out_value_next = out_value_reg;
        out_kind_next  = out_kind_reg;
        if (s_tready) begin
            in_valid_next = s_tvalid;
            if (s_tvalid) begin
                in_item_next = s_item;
            end
        end
        if (advance) begin
            out_valid_next = 1'b1;
            out_value_next = read_value;
            out_kind_next  = ctrl.kind;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
        in_item_reg   <= in_item_next;
        out_value_reg <= out_value_next;
        out_kind_reg  <= out_kind_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(8 - VAL_W){1'b0}}, out_value_reg};
    assign m_tuser  = out_kind_reg;

`ifndef SYNTHESIS
    a_no_move_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && in_item_reg.opcode != OP_MOVE |=> out_kind_reg == MK_NONE)
        else $error("non-move transaction reported a move kind");

    a_value_range: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> 32'(out_value_reg) < CELLS)
        else $error("read value outside the square");

    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> s_tready)
        else $error("empty input register refused a transaction");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_item_reg))
        else $error("stalled transaction lost from the input register");
`endif

endmodule

FILE: rtl/kse_move_select.sv
// opcode decode and move kind selection from the uniform draw
// depends on kse_pkg
module kse_move_select import kse_pkg::*; (
    input  item_t      item,
    output move_ctrl_t ctrl
);

    always_comb begin
        ctrl.load  = 1'b0;
        ctrl.apply = 1'b0;
        ctrl.kind  = MK_NONE;
        unique case (item.opcode)
            OP_LOAD: begin
                ctrl.load = 1'b1;
            end
            OP_MOVE: begin
                ctrl.apply = 1'b1;
                priority if (item.move_draw < CUT_CELL) begin
                    ctrl.kind = MK_CELL;
                end else if (item.move_draw < CUT_ROWS) begin
                    ctrl.kind = MK_ROWS;
                end else if (item.move_draw < CUT_COLS) begin
                    ctrl.kind = MK_COLS;
                end else if (item.move_draw < CUT_REV) begin
                    ctrl.kind = MK_REV;
                end else if (item.move_draw < CUT_FROWS) begin
                    ctrl.kind = MK_FROWS;
                end else begin
                    ctrl.kind = MK_FCOLS;
                end
            end
            OP_READ: begin
                ctrl.kind = MK_NONE;
            end
            default: begin
                ctrl.kind = MK_NONE;
            end
        endcase
    end

endmodule

FILE: rtl/kse_square_bank.sv
// register bank for both key squares, applies at most one permutation or identity load per transaction
// and returns the addressed cell after the update; depends on kse_pkg
module kse_square_bank import kse_pkg::*; #(
    parameter int SIDE  = SIDE_DEF,
    parameter int CELLS = CELLS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               advance,
    input  item_t              item,
    input  move_ctrl_t         ctrl,
    output logic [VAL_W-1:0]   read_value
);

    localparam int IDX_W = (CELLS > 1) ? $clog2(CELLS) : 1;

    logic [1:0][CELLS-1:0][VAL_W-1:0] sq_reg;
    logic [CELLS-1:0][VAL_W-1:0]      cur;
    logic [CELLS-1:0][VAL_W-1:0]      sq_next;
    logic                             cell_ok;
    logic                             line_ok;

    always_comb begin
        cur     = sq_reg[item.square_sel];
        cell_ok = (32'(item.cell_a) < CELLS) && (32'(item.cell_b) < CELLS);
        line_ok = (32'(item.line_a) < SIDE) && (32'(item.line_b) < SIDE);
    end

    for (genvar gi = 0; gi < CELLS; gi++) begin : g_cell
        localparam int ROW = gi / SIDE;
        localparam int COL = gi % SIDE;
        logic [IDX_W-1:0] src;

        always_comb begin
            src = IDX_W'(gi);
            if (ctrl.apply) begin
                unique case (ctrl.kind)
                    MK_CELL: begin
                        if (cell_ok) begin
                            if (32'(item.cell_a) == gi) begin
                                src = IDX_W'(item.cell_b);
                            end else if (32'(item.cell_b) == gi) begin
                                src = IDX_W'(item.cell_a);
                            end
                        end
                    end
                    MK_ROWS: begin
                        if (line_ok) begin
                            if (32'(item.line_a) == ROW) begin
                                src = IDX_W'(32'(item.line_b) * SIDE + COL);
                            end else if (32'(item.line_b) == ROW) begin
                                src = IDX_W'(32'(item.line_a) * SIDE + COL);
                            end
                        end
                    end
                    MK_COLS: begin
                        if (line_ok) begin
                            if (32'(item.line_a) == COL) begin
                                src = IDX_W'(ROW * SIDE + 32'(item.line_b));
                            end else if (32'(item.line_b) == COL) begin
                                src = IDX_W'(ROW * SIDE + 32'(item.line_a));
                            end
                        end
                    end
                    MK_REV: begin
                        src = IDX_W'(CELLS - 1 - gi);
                    end
                    MK_FROWS: begin
                        src = IDX_W'((SIDE - 1 - ROW) * SIDE + COL);
                    end
                    MK_FCOLS: begin
                        src = IDX_W'(ROW * SIDE + SIDE - 1 - COL);
                    end
                    default: begin
                        src = IDX_W'(gi);
                    end
                endcase
            end
        end

        assign sq_next[gi] = ctrl.load ? VAL_W'(gi) : cur[src];
    end

    always_comb begin
        read_value = '0;
        for (int k = 0; k < CELLS; k++) begin
            if (32'(item.cell_a) == k) begin
                read_value = sq_next[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 0; s < 2; s++) begin
                for (int k = 0; k < CELLS; k++) begin
                    sq_reg[s][k] <= VAL_W'(k);
                end
            end
        end else if (advance) begin
            sq_reg[item.square_sel] <= sq_next;
        end
    end

`ifndef SYNTHESIS
    a_idle_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        aresetn && !advance |=> $stable(sq_reg))
        else $error("square bank changed without a transaction");

    a_sq1_untouched: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && !item.square_sel |=> $stable(sq_reg[1]))
        else $error("square 1 changed by a square 0 transaction");

    a_sq0_untouched: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && item.square_sel |=> $stable(sq_reg[0]))
        else $error("square 0 changed by a square 1 transaction");

    a_load_origin: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && ctrl.load && !item.square_sel |=> sq_reg[0][0] == '0)
        else $error("identity load did not reach square 0");
`endif

endmodule

FILE: dv/key_square_move_engine_test.sv
// self-checking testbench for key_square_move_engine: directed and random transactions,
// random stalls on both stream sides, results checked against a tracked copy of both squares
// depends on kse_pkg and the key_square_move_engine rtl
`timescale 1ns / 1ps

module key_square_move_engine_test;
    import kse_pkg::*;

    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
    localparam int RANDOM_ITEMS = 1800;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int REPORT_MAX   = 10;

    typedef struct {
        logic [VAL_W-1:0] value;
        kind_t            kind;
    } cell_read_t;

    class key_square_tracker;
        logic [VAL_W-1:0] squares [2][CELLS_DEF];
        cell_read_t       read_queue [$];
        int               mismatch_count;

        function new();
            mismatch_count = 0;
            for (int s = 0; s < 2; s++) begin
                load_identity(s);
            end
        endfunction

        function void load_identity(int s);
            for (int i = 0; i < CELLS_DEF; i++) begin
                squares[s][i] = VAL_W'(i);
            end
        endfunction

        function void swap_pair(int s, int a, int b);
            logic [VAL_W-1:0] hold;
            if (a >= CELLS_DEF || b >= CELLS_DEF) begin
                return;
            end
            hold          = squares[s][a];
            squares[s][a] = squares[s][b];
            squares[s][b] = hold;
        endfunction

        // rows when by_row is set, columns otherwise
        function void swap_line(int s, int a, int b, bit by_row);
            if (a >= SIDE_DEF || b >= SIDE_DEF) begin
                return;
            end
            for (int k = 0; k < SIDE_DEF; k++) begin
                if (by_row) begin
                    swap_pair(s, a * SIDE_DEF + k, b * SIDE_DEF + k);
                end else begin
                    swap_pair(s, k * SIDE_DEF + a, k * SIDE_DEF + b);
                end
            end
        endfunction

        function void note_item(logic [OP_W-1:0] op, logic sel, logic [DRAW_W-1:0] draw,
                                logic [CELL_W-1:0] ca, logic [CELL_W-1:0] cb,
                                logic [LINE_W-1:0] la, logic [LINE_W-1:0] lb);
            cell_read_t exp_read;
            int s;
            s = int'(sel);
            exp_read.kind = MK_NONE;
            if (op == OP_LOAD) begin
                load_identity(s);
            end else if (op == OP_MOVE) begin
                if (draw < CUT_CELL) begin
                    exp_read.kind = MK_CELL;
                    swap_pair(s, ca, cb);
                end else if (draw < CUT_ROWS) begin
                    exp_read.kind = MK_ROWS;
                    swap_line(s, la, lb, 1'b1);
                end else if (draw < CUT_COLS) begin
                    exp_read.kind = MK_COLS;
                    swap_line(s, la, lb, 1'b0);
                end else if (draw < CUT_REV) begin
                    exp_read.kind = MK_REV;
                    for (int i = 0; i < CELLS_DEF / 2; i++) begin
                        swap_pair(s, i, CELLS_DEF - 1 - i);
                    end
                end else if (draw < CUT_FROWS) begin
                    exp_read.kind = MK_FROWS;
                    for (int i = 0; i < SIDE_DEF / 2; i++) begin
                        swap_line(s, i, SIDE_DEF - 1 - i, 1'b1);
                    end
                end else begin
                    exp_read.kind = MK_FCOLS;
                    for (int i = 0; i < SIDE_DEF / 2; i++) begin
                        swap_line(s, i, SIDE_DEF - 1 - i, 1'b0);
                    end
                end
            end
            exp_read.value = (ca < CELLS_DEF) ? squares[s][ca] : '0;
            read_queue.push_back(exp_read);
        endfunction

        function void check_read(logic [VAL_W-1:0] value, logic [KIND_W-1:0] kind);
            cell_read_t exp_read;
            if (read_queue.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_MAX) begin
                    $display("unexpected result transaction: read_value %0d move_kind %0d",
                             value, kind);
                end
                return;
            end
            exp_read = read_queue.pop_front();
            if (value !== exp_read.value || kind !== exp_read.kind) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_MAX) begin
                    $display("mismatch: read_value exp %0d got %0d, move_kind exp %0d got %0d",
                             exp_read.value, value, exp_read.kind, kind);
                end
            end
        endfunction

        function int pending();
            return read_queue.size();
        endfunction
    endclass

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;   // move_draw, cell_a, cell_b, line_a, line_b
    logic [2:0]  s_tuser  = '0;   // opcode, square_sel
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;         // read_value, zero fill
    logic [2:0]  m_tuser;         // move_kind

    key_square_tracker tracker;
    int  cycle_count = 0;
    bit  send_quiet  = 1'b0;

    key_square_move_engine i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic send_item(logic [OP_W-1:0] op, logic sel, logic [DRAW_W-1:0] draw,
                             logic [CELL_W-1:0] ca, logic [CELL_W-1:0] cb,
                             logic [LINE_W-1:0] la, logic [LINE_W-1:0] lb);
        int gap;
        gap = send_quiet ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {lb, la, cb, ca, draw};
        s_tuser  <= {sel, op};
        do @(posedge aclk); while (!s_tready);
        tracker.note_item(op, sel, draw, ca, cb, la, lb);
    endtask

    task automatic send_random();
        logic [OP_W-1:0]   op;
        logic [DRAW_W-1:0] draw;
        logic [CELL_W-1:0] ca;
        logic [CELL_W-1:0] cb;
        logic [LINE_W-1:0] la;
        logic [LINE_W-1:0] lb;
        int pick;
        pick = $urandom_range(0, 99);
        op = (pick < 6) ? OP_LOAD : (pick < 70) ? OP_MOVE : (pick < 92) ? OP_READ : OP_SPARE;
        // bias the draw so the rarer move kinds show up often
        case ($urandom_range(0, 9))
            5:       draw = DRAW_W'($urandom_range(CUT_CELL, CUT_ROWS - 1));
            6:       draw = DRAW_W'($urandom_range(CUT_ROWS, CUT_COLS - 1));
            7:       draw = DRAW_W'($urandom_range(CUT_COLS, CUT_REV - 1));
            8:       draw = DRAW_W'($urandom_range(CUT_REV, CUT_FROWS - 1));
            9:       draw = DRAW_W'($urandom_range(CUT_FROWS, 65535));
            default: draw = DRAW_W'($urandom_range(0, 65535));
        endcase
        ca = ($urandom_range(0, 9) == 0) ? CELL_W'($urandom_range(CELLS_DEF, 31))
                                          : CELL_W'($urandom_range(0, CELLS_DEF - 1));
        cb = ($urandom_range(0, 9) == 0) ? CELL_W'($urandom_range(CELLS_DEF, 31))
                                          : CELL_W'($urandom_range(0, CELLS_DEF - 1));
        la = ($urandom_range(0, 9) == 0) ? LINE_W'($urandom_range(SIDE_DEF, 7))
                                          : LINE_W'($urandom_range(0, SIDE_DEF - 1));
        lb = ($urandom_range(0, 9) == 0) ? LINE_W'($urandom_range(SIDE_DEF, 7))
                                          : LINE_W'($urandom_range(0, SIDE_DEF - 1));
        send_item(op, 1'($urandom_range(0, 1)), draw, ca, cb, la, lb);
    endtask

    // result side: random stall per transaction, with stall-free stretches
    initial begin
        int stall;
        int taken;
        bit recv_quiet;
        taken = 0;
        recv_quiet = 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            if (taken % 120 == 0) begin
                recv_quiet = ($urandom_range(0, 3) == 0);
            end
            stall = recv_quiet ? 0 : $urandom_range(0, 6);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            tracker.check_read(m_tdata[VAL_W-1:0], m_tuser);
            taken++;
        end
    end

    initial begin
        tracker = new();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // reset contents, read edges and the spare opcode
        send_item(OP_READ,  1'b0, 16'h0000, 5'd0,  5'd0,  3'd0, 3'd0);
        send_item(OP_READ,  1'b1, 16'hffff, 5'd24, 5'd31, 3'd7, 3'd7);
        send_item(OP_READ,  1'b0, 16'h1234, 5'd25, 5'd3,  3'd1, 3'd2);
        send_item(OP_READ,  1'b1, 16'h0000, 5'd31, 5'd0,  3'd0, 3'd0);
        send_item(OP_SPARE, 1'b0, 16'h0000, 5'd7,  5'd9,  3'd1, 3'd3);
        // every move kind on both sides of each cut point
        send_item(OP_MOVE,  1'b0, 16'h0000,               5'd0,  5'd24, 3'd0, 3'd4);
        send_item(OP_MOVE,  1'b0, DRAW_W'(CUT_CELL - 1),  5'd3,  5'd17, 3'd1, 3'd2);
        send_item(OP_MOVE,  1'b0, CUT_CELL,               5'd5,  5'd1,  3'd0, 3'd4);
        send_item(OP_MOVE,  1'b1, DRAW_W'(CUT_ROWS - 1),  5'd12, 5'd2,  3'd1, 3'd3);
        send_item(OP_MOVE,  1'b1, CUT_ROWS,               5'd6,  5'd8,  3'd0, 3'd4);
        send_item(OP_MOVE,  1'b1, DRAW_W'(CUT_COLS - 1),  5'd20, 5'd2,  3'd2, 3'd3);
        send_item(OP_MOVE,  1'b0, CUT_COLS,               5'd4,  5'd8,  3'd0, 3'd0);
        send_item(OP_MOVE,  1'b0, DRAW_W'(CUT_REV - 1),   5'd0,  5'd8,  3'd0, 3'd0);
        send_item(OP_MOVE,  1'b1, CUT_REV,                5'd21, 5'd8,  3'd0, 3'd0);
        send_item(OP_MOVE,  1'b1, DRAW_W'(CUT_FROWS - 1), 5'd2,  5'd8,  3'd0, 3'd0);
        send_item(OP_MOVE,  1'b0, CUT_FROWS,              5'd9,  5'd8,  3'd0, 3'd0);
        send_item(OP_MOVE,  1'b1, 16'hffff,               5'd14, 5'd8,  3'd0, 3'd0);
        // out-of-range and same-index moves change nothing, then identity loads of both squares
        send_item(OP_MOVE,  1'b0, 16'h0100,      5'd2,  5'd31, 3'd0, 3'd0);
        send_item(OP_MOVE,  1'b0, 16'h0200,      5'd30, 5'd2,  3'd0, 3'd0);
        send_item(OP_MOVE,  1'b1, CUT_CELL,      5'd1,  5'd1,  3'd7, 3'd1);
        send_item(OP_MOVE,  1'b1, CUT_ROWS,      5'd1,  5'd1,  3'd2, 3'd5);
        send_item(OP_MOVE,  1'b0, 16'h7fff,      5'd11, 5'd11, 3'd3, 3'd3);
        send_item(OP_MOVE,  1'b0, CUT_ROWS,      5'd11, 5'd11, 3'd3, 3'd3);
        send_item(OP_LOAD,  1'b0, 16'h0000,      5'd13, 5'd0,  3'd0, 3'd0);
        send_item(OP_LOAD,  1'b1, 16'hffff,      5'd29, 5'd31, 3'd7, 3'd7);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 150 == 0) begin
                send_quiet = ($urandom_range(0, 3) == 0);
            end
            send_random();
        end
        s_tvalid <= 1'b0;

        while (tracker.pending() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (tracker.mismatch_count == 0 && tracker.pending() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
